// File: hw/rtl/ahr_pkg.sv
// Shared types and constants for the HID report deframer.
// No dependencies; imported by every module of the block.
package ahr_pkg;

    // Header tag carried in byte 2 of every report
    localparam logic [7:0] HID_TAG = 8'h05;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LEN = 2'd1;

    localparam logic [15:0] CHANNEL_ID_RST = 16'd257;
    localparam logic [15:0] MAX_LEN_RST    = 16'd257;

    // Error codes on the result channel
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_SEQ     = 2'd1;
    localparam logic [1:0] ERR_TOO_BIG = 2'd2;

    // Defaults for the top-level parameters
    localparam int REPORT_BYTES_DEF = 64;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Result kinds queued between parser and output stage
    typedef enum logic [2:0] {
        KIND_DATA,
        KIND_LAST,
        KIND_EMPTY,
        KIND_SEQ_ERR,
        KIND_LEN_ERR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [15:0] length;
    } t_cmd;

endpackage

// File: hw/rtl/ahr_parser.sv
// Front end: tracks report position, checks headers and queues results.
// Depends on ahr_pkg.
module ahr_parser #(
    parameter int REPORT_BYTES = ahr_pkg::REPORT_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_report_byte,
    input  logic [15:0]   i_channel_id,
    input  logic [15:0]   i_max_len,
    output logic          o_push,
    output ahr_pkg::t_cmd o_cmd
);
    import ahr_pkg::*;

    localparam int PW = $clog2(REPORT_BYTES);
    localparam logic [PW-1:0] POS_LAST = PW'(REPORT_BYTES - 1);
    localparam logic [PW-1:0] POS_1 = PW'(1);
    localparam logic [PW-1:0] POS_2 = PW'(2);
    localparam logic [PW-1:0] POS_3 = PW'(3);
    localparam logic [PW-1:0] POS_4 = PW'(4);
    localparam logic [PW-1:0] POS_5 = PW'(5);
    localparam logic [PW-1:0] POS_6 = PW'(6);

    logic [PW-1:0] r_pos, n_pos;
    logic [15:0]   r_exp_seq, n_exp_seq;
    logic [15:0]   r_ann_len, n_ann_len;
    logic [15:0]   r_rcvd, n_rcvd;
    logic [7:0]    r_hi, n_hi;
    logic          r_skip, n_skip;

    logic [15:0] w_word;
    logic [15:0] w_rcvd_inc;
    logic        w_first;

    assign w_word     = {r_hi, i_report_byte};
    assign w_rcvd_inc = r_rcvd + 16'd1;
    assign w_first    = (r_exp_seq == 16'd1);

    always_comb begin
        n_pos     = r_pos;
        n_exp_seq = r_exp_seq;
        n_ann_len = r_ann_len;
        n_rcvd    = r_rcvd;
        n_hi      = r_hi;
        n_skip    = r_skip;
        o_push    = 1'b0;
        o_cmd.kind   = KIND_DATA;
        o_cmd.data   = i_report_byte;
        o_cmd.length = r_ann_len;

        if (i_accept) begin
            n_pos = (r_pos == POS_LAST) ? '0 : r_pos + PW'(1);
            if (r_pos == '0) begin
                n_skip = 1'b0;
                n_hi   = i_report_byte;
            end else if (!r_skip) begin
                if (r_pos == POS_1) begin
                    if (w_word != i_channel_id) n_skip = 1'b1;
                end else if (r_pos == POS_2) begin
                    if (i_report_byte != HID_TAG) n_skip = 1'b1;
                end else if (r_pos == POS_3) begin
                    n_hi = i_report_byte;
                end else if (r_pos == POS_4) begin
                    if (w_word != r_exp_seq) begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_SEQ_ERR;
                        n_exp_seq  = '0;
                        n_rcvd     = '0;
                        n_skip     = 1'b1;
                    end else begin
                        n_exp_seq = r_exp_seq + 16'd1;
                        if (w_word == 16'd0) n_rcvd = '0;
                    end
                end else if (w_first && r_pos == POS_5) begin
                    n_hi = i_report_byte;
                end else if (w_first && r_pos == POS_6) begin
                    // first frame: announced length
                    n_ann_len    = w_word;
                    n_rcvd       = '0;
                    o_cmd.length = w_word;
                    if (w_word > i_max_len) begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_LEN_ERR;
                        n_exp_seq  = '0;
                        n_skip     = 1'b1;
                    end else if (w_word == 16'd0) begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_EMPTY;
                        n_exp_seq  = '0;
                        n_skip     = 1'b1;
                    end
                end else if (r_rcvd < r_ann_len) begin
                    o_push = 1'b1;
                    n_rcvd = w_rcvd_inc;
                    if (w_rcvd_inc == r_ann_len) begin
                        o_cmd.kind = KIND_LAST;
                        n_exp_seq  = '0;
                        n_rcvd     = '0;
                        n_skip     = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_exp_seq <= '0;
            r_ann_len <= '0;
            r_rcvd    <= '0;
            r_hi      <= '0;
            r_skip    <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_exp_seq <= n_exp_seq;
            r_ann_len <= n_ann_len;
            r_rcvd    <= n_rcvd;
            r_hi      <= n_hi;
            r_skip    <= n_skip;
        end
    end

endmodule

// File: hw/rtl/ahr_queue.sv
// Short result queue between parser and output stage.
// Depends on ahr_pkg for the queued entry type.
module ahr_queue #(
    parameter int DEPTH = ahr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ahr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output ahr_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import ahr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + AW'(1);
            if (i_pop)  r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + AW'(1);
            if (i_push && !i_pop)      r_count <= r_count + CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - CW'(1);
        end
    end

endmodule

// File: hw/rtl/ahr_out.sv
// Back end: decodes queued results into output fields, registered.
// Depends on ahr_pkg.
module ahr_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_avail,
    input  ahr_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [7:0]    o_payload_byte,
    output logic          o_byte_valid,
    output logic          o_end_of_message,
    output logic [1:0]    o_error_code,
    output logic [15:0]   o_message_length
);
    import ahr_pkg::*;

    logic        r_valid;
    logic [7:0]  r_data, n_data;
    logic        r_bvalid, n_bvalid;
    logic        r_eom, n_eom;
    logic [1:0]  r_err, n_err;
    logic [15:0] r_len;

    assign o_pop = i_avail && (!r_valid || i_ready);

    always_comb begin
        n_data   = '0;
        n_bvalid = 1'b0;
        n_eom    = 1'b0;
        n_err    = ERR_NONE;
        case (i_cmd.kind)
            KIND_DATA: begin
                n_data   = i_cmd.data;
                n_bvalid = 1'b1;
            end
            KIND_LAST: begin
                n_data   = i_cmd.data;
                n_bvalid = 1'b1;
                n_eom    = 1'b1;
            end
            KIND_EMPTY:   n_eom = 1'b1;
            KIND_SEQ_ERR: n_err = ERR_SEQ;
            KIND_LEN_ERR: n_err = ERR_TOO_BIG;
            default:      n_err = ERR_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data   <= n_data;
            r_bvalid <= n_bvalid;
            r_eom    <= n_eom;
            r_err    <= n_err;
            r_len    <= i_cmd.length;
        end
    end

    assign o_valid          = r_valid;
    assign o_payload_byte   = r_data;
    assign o_byte_valid     = r_bvalid;
    assign o_end_of_message = r_eom;
    assign o_error_code     = r_err;
    assign o_message_length = r_len;

endmodule

// File: hw/rtl/apdu_hid_frame_reassembler.sv
// Top level of the APDU-over-HID deframer: config registers and wiring.
// Depends on ahr_pkg, ahr_parser, ahr_queue and ahr_out.
//
//  Channel   Signals                                  Direction  Handshake
//  -------   ---------------------------------------  ---------  -----------------
//  report    i_report_byte                            in         i_valid / o_ready
//  result    o_payload_byte, o_byte_valid,            out        o_valid / i_ready
//            o_end_of_message, o_error_code,
//            o_message_length
//  config    i_cfg_idx, i_cfg_wdata                   in         i_cfg_we (no wait)
//
// One report byte per cycle is taken while the result queue has room; the
// parser state (position, sequence, lengths) updates in that same cycle.
// A result goes through the result queue and then the output register, and
// there is at most one result per byte.
// Reset (synchronous, active low) clears the parser, the queue pointers and
// the output valid; the config registers return to channel 257 / max 257.
// A stalled result holds in the output register while the queue keeps
// absorbing requests; o_ready drops only when the queue is full.
module apdu_hid_frame_reassembler #(
    parameter int REPORT_BYTES = ahr_pkg::REPORT_BYTES_DEF,
    parameter int QUEUE_DEPTH  = ahr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_report_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_payload_byte,
    output logic                          o_byte_valid,
    output logic                          o_end_of_message,
    output logic [1:0]                    o_error_code,
    output logic [15:0]                   o_message_length,
    input  logic                          i_cfg_we,
    input  logic [ahr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_wdata
);
    import ahr_pkg::*;

    logic [15:0] r_channel_id;
    logic [15:0] r_max_len;

    logic accept;
    logic push, pop, q_full, q_empty;
    t_cmd push_cmd, head_cmd;

    // Config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_id <= CHANNEL_ID_RST;
            r_max_len    <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_CHANNEL: r_channel_id <= i_cfg_wdata;
                CFG_IDX_MAX_LEN: r_max_len    <= i_cfg_wdata;
                default:         r_max_len    <= r_max_len;
            endcase
        end
    end

    // Any byte may produce a result, so only a full queue stalls the input
    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    ahr_parser #(
        .REPORT_BYTES(REPORT_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_report_byte(i_report_byte),
        .i_channel_id (r_channel_id),
        .i_max_len    (r_max_len),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    ahr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_cmd  (head_cmd),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    ahr_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (!q_empty),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_payload_byte  (o_payload_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_message(o_end_of_message),
        .o_error_code    (o_error_code),
        .o_message_length(o_message_length)
    );

endmodule

// File: sim/ahr_result_checker.sv
// Result checker for the HID report deframer: mirrors the parser on every
// accepted report byte and compares each accepted result in order.
// Depends on ahr_pkg; instantiated by tb beside the block.
`timescale 1ns / 100ps

module ahr_result_checker #(
    parameter int REPORT_BYTES = ahr_pkg::REPORT_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic [7:0]                    i_report_byte,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [7:0]                    i_payload_byte,
    input  logic                          i_byte_valid,
    input  logic                          i_end_of_message,
    input  logic [1:0]                    i_error_code,
    input  logic [15:0]                   i_message_length,
    input  logic                          i_cfg_we,
    input  logic [ahr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ahr_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        byte_valid;
        logic        eom;
        logic [1:0]  err;
        logic [15:0] len;
    } t_msg_result;

    t_msg_result expected_q[$];

    // mirrored parser state
    int unsigned rpt_pos;
    logic [15:0] want_seq;
    logic [15:0] ann_len;
    logic [15:0] rx_count;
    logic [7:0]  hdr_hi;
    logic        skip_rest;
    logic [15:0] cfg_channel;
    logic [15:0] cfg_max_len;

    int fail_n = 0;

    // back to waiting for sequence 0, rest of the report ignored
    function automatic void drop_message();
        want_seq  = '0;
        rx_count  = '0;
        skip_rest = 1'b1;
    endfunction

    // advances the mirrored parser by one byte; returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, output t_msg_result r);
        int unsigned p;
        logic [15:0] seq;
        p = rpt_pos;
        r = '0;
        rpt_pos = (p + 1 >= REPORT_BYTES) ? 0 : p + 1;
        if (p == 0) begin
            skip_rest = 1'b0;
            hdr_hi    = b;
            return 1'b0;
        end
        if (skip_rest)
            return 1'b0;
        if (p == 1) begin
            if ({hdr_hi, b} != cfg_channel)
                skip_rest = 1'b1;
            return 1'b0;
        end
        if (p == 2) begin
            if (b != HID_TAG)
                skip_rest = 1'b1;
            return 1'b0;
        end
        if (p == 3) begin
            hdr_hi = b;
            return 1'b0;
        end
        if (p == 4) begin
            seq = {hdr_hi, b};
            if (seq != want_seq) begin
                r.err = ERR_SEQ;
                r.len = ann_len;
                drop_message();
                return 1'b1;
            end
            want_seq = want_seq + 16'd1;
            if (seq == 16'd0)
                rx_count = '0;
            return 1'b0;
        end
        if (want_seq == 16'd1 && p == 5) begin
            hdr_hi = b;
            return 1'b0;
        end
        if (want_seq == 16'd1 && p == 6) begin
            ann_len  = {hdr_hi, b};
            rx_count = '0;
            r.len    = ann_len;
            if (ann_len > cfg_max_len) begin
                r.err = ERR_TOO_BIG;
                drop_message();
                return 1'b1;
            end
            if (ann_len == 16'd0) begin
                r.eom = 1'b1;
                drop_message();
                return 1'b1;
            end
            return 1'b0;
        end
        if (rx_count < ann_len) begin
            rx_count     = rx_count + 16'd1;
            r.data       = b;
            r.byte_valid = 1'b1;
            r.len        = ann_len;
            if (rx_count >= ann_len) begin
                r.eom = 1'b1;
                drop_message();
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_msg_result want;
        t_msg_result got;
        if (!i_rst_n) begin
            rpt_pos     = 0;
            want_seq    = '0;
            ann_len     = '0;
            rx_count    = '0;
            hdr_hi      = '0;
            skip_rest   = 1'b0;
            cfg_channel = CHANNEL_ID_RST;
            cfg_max_len = MAX_LEN_RST;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_CHANNEL)
                    cfg_channel = i_cfg_wdata;
                else if (i_cfg_idx == CFG_IDX_MAX_LEN)
                    cfg_max_len = i_cfg_wdata;
            end
            if (i_req_valid && i_req_ready) begin
                if (deframe_byte(i_report_byte, want))
                    expected_q.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                got = {i_payload_byte, i_byte_valid, i_end_of_message,
                       i_error_code, i_message_length};
                if (expected_q.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("%0t: unexpected result data=%h bv=%b eom=%b err=%0d len=%0d",
                                 $realtime, got.data, got.byte_valid, got.eom, got.err,
                                 got.len);
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        fail_n++;
                        if (fail_n <= 10)
                            $display({"%0t: result mismatch: expected data=%h bv=%b eom=%b ",
                                      "err=%0d len=%0d, got data=%h bv=%b eom=%b err=%0d ",
                                      "len=%0d"},
                                     $realtime, want.data, want.byte_valid, want.eom,
                                     want.err, want.len, got.data, got.byte_valid, got.eom,
                                     got.err, got.len);
                    end
                end
            end
        end
        o_fail_count <= fail_n;
        o_pending    <= expected_q.size();
    end

endmodule

// File: sim/tb.sv
// Top of the HID report deframer testbench: clock, reset, report stimulus,
// result-side stalls, watchdog and verdict.
// Depends on ahr_pkg, apdu_hid_frame_reassembler and ahr_result_checker.
`timescale 1ns / 100ps

module tb;
    import ahr_pkg::*;

    localparam int REPORT_BYTES   = REPORT_BYTES_DEF;
    // report bytes for the whole run, directed part included
    localparam int TOTAL_BYTES    = 1750;
    localparam int WATCHDOG_LIMIT = 4000;
    // queue depth plus output register, with margin
    localparam int SETTLE_CYCLES  = 24;

    // indexes past the two real registers; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_valid          = 1'b0;
    logic                 o_ready;
    logic [7:0]           i_report_byte    = '0;
    logic                 o_valid;
    logic                 i_ready          = 1'b0;
    logic [7:0]           o_payload_byte;
    logic                 o_byte_valid;
    logic                 o_end_of_message;
    logic [1:0]           o_error_code;
    logic [15:0]          o_message_length;
    logic                 i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx        = '0;
    logic [15:0]          i_cfg_wdata      = '0;

    int fail_count;
    int pending;

    // stimulus-side copy of the register settings, used to build headers
    logic [15:0] cur_channel = CHANNEL_ID_RST;
    logic [15:0] cur_max     = MAX_LEN_RST;
    // payload bytes still to be carried by the frames of the current message
    logic [7:0]  tx_body[$];
    int          burst_left  = 0;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    t_rx_mode    rx_mode     = RX_STEADY;
    int          rx_mode_left = 0;
    int          rx_phase    = 0;

    always #10 i_clk = ~i_clk;

    apdu_hid_frame_reassembler i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_report_byte    (i_report_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_payload_byte   (o_payload_byte),
        .o_byte_valid     (o_byte_valid),
        .o_end_of_message (o_end_of_message),
        .o_error_code     (o_error_code),
        .o_message_length (o_message_length),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    ahr_result_checker #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_report_byte    (i_report_byte),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_payload_byte   (o_payload_byte),
        .i_byte_valid     (o_byte_valid),
        .i_end_of_message (o_end_of_message),
        .i_error_code     (o_error_code),
        .i_message_length (o_message_length),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Result side: ready follows one of several stall patterns, each held
    // for a random stretch. Steady mode gives runs with no stalls at all.
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(16, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            RX_STEADY: i_ready <= 1'b1;
            RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_ready <= ($urandom_range(0, 5) == 0);
            default:   i_ready <= (rx_phase % 4 != 3);
        endcase
    end

    // Watchdog: any cycle without a request or result moving counts toward
    // the limit; a hung block ends the run here.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One report byte as one request. Starts at the next falling edge and
    // returns at the rising edge where the request was taken, so valid stays
    // high into the next byte unless a burst ends.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 20);
            repeat (gap) @(negedge i_clk);
            case ($urandom_range(0, 9))
                0, 1, 2:       burst_left = $urandom_range(1, 3);
                3, 4, 5, 6, 7: burst_left = $urandom_range(4, 48);
                default:       burst_left = $urandom_range(100, 400);
            endcase
        end
        i_valid       <= 1'b1;
        i_report_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    // Drop valid, wait until every expected result is out, then give the
    // block time to finish bytes that produce no result. Ends at a falling
    // edge with nothing driven yet in that step.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Entered at a falling edge; waiting again after the enable is lowered keeps
    // it from being lowered and raised in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] chan, input logic [15:0] max_len);
        write_reg(CFG_IDX_CHANNEL, chan);
        write_reg(CFG_IDX_MAX_LEN, max_len);
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                      16'($urandom_range(0, 65535)));
        cur_channel = chan;
        cur_max     = max_len;
    endtask

    // One whole report. With carry set, the payload area is filled from
    // tx_body; whatever is left over is random padding.
    task automatic send_frame(input logic [15:0] chan, input logic [7:0] tag,
                              input logic [15:0] seq, input bit first,
                              input logic [15:0] len, input bit carry);
        logic [7:0] b;
        for (int i = 0; i < REPORT_BYTES; i++) begin
            if (i == 0)
                b = chan[15:8];
            else if (i == 1)
                b = chan[7:0];
            else if (i == 2)
                b = tag;
            else if (i == 3)
                b = seq[15:8];
            else if (i == 4)
                b = seq[7:0];
            else if (first && i == 5)
                b = len[15:8];
            else if (first && i == 6)
                b = len[7:0];
            else if (carry && tx_body.size() != 0)
                b = tx_body.pop_front();
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b);
        end
    endtask

    // A report the block must skip whole (foreign channel or bad tag), or
    // plain garbage that the parser sorts out on its own.
    task automatic send_noise();
        logic [7:0] tg;
        int pick;
        pick = $urandom_range(0, 99);
        tg   = 8'($urandom_range(0, 255));
        if (tg == HID_TAG)
            tg = ~HID_TAG;
        if (pick < 50)
            send_frame(cur_channel ^ 16'($urandom_range(1, 65535)), HID_TAG,
                       16'($urandom_range(0, 65535)), 1'b0, 16'd0, 1'b0);
        else if (pick < 85)
            send_frame(cur_channel, tg, 16'($urandom_range(0, 65535)), 1'b0, 16'd0, 1'b0);
        else
            send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), 1'b0, 16'd0, 1'b0);
    endtask

    // A message announcing len and carrying nbytes payload bytes (fewer than
    // len leaves it unfinished). noise and broken are percentages per
    // continuation frame: a skipped report slipped in, or a frame with the
    // wrong sequence that abandons the message.
    task automatic send_message(input logic [15:0] len, input int nbytes,
                                input int noise, input int broken);
        logic [15:0] seq;
        int pick;
        tx_body.delete();
        repeat (nbytes) tx_body.push_back(8'($urandom_range(0, 255)));
        send_frame(cur_channel, HID_TAG, 16'd0, 1'b1, len, 1'b1);
        seq = 16'd1;
        while (tx_body.size() != 0) begin
            pick = $urandom_range(0, 99);
            if (pick < noise) begin
                send_noise();
            end else if (pick < noise + broken) begin
                send_frame(cur_channel, HID_TAG, seq ^ 16'($urandom_range(1, 65535)),
                           1'b0, 16'd0, 1'b0);
                tx_body.delete();
            end else begin
                send_frame(cur_channel, HID_TAG, seq, 1'b0, 16'd0, 1'b1);
                seq = seq + 16'd1;
            end
        end
    endtask

    initial begin
        int pick;
        int lim;
        int msgs_left;
        logic [15:0] len;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases at the reset settings (channel 257, max 257)
        send_message(16'd3, 3, 0, 0);          // short message, padding dropped
        send_message(16'd0, 0, 0, 0);          // zero length completes at once
        send_message(16'd257, 257, 0, 0);      // exactly the maximum, five frames
        send_message(16'd258, 0, 0, 0);        // one over the maximum
        send_frame(16'h0100, HID_TAG, 16'd0, 1'b1, 16'd5, 1'b0); // low channel byte off
        send_frame(cur_channel, 8'h04, 16'd0, 1'b1, 16'd5, 1'b0); // bad tag
        send_frame(cur_channel, HID_TAG, 16'hFFFF, 1'b0, 16'd0, 1'b0); // stray frame while idle
        send_message(16'd100, 100, 0, 100);    // second frame out of sequence
        send_message(16'd10, 10, 0, 0);        // recovery after the error

        // Extremes: channel 0, nothing but empty messages allowed
        settle();
        set_config(16'h0000, 16'h0000);
        write_reg(CFG_IDX_SPARE_A, 16'hFFFF);
        write_reg(CFG_IDX_SPARE_B, 16'h0000);
        send_message(16'd0, 0, 0, 0);
        send_message(16'd1, 0, 0, 0);
        send_message(16'hFFFF, 0, 0, 0);

        // Extremes: channel 0xFFFF, any length allowed
        settle();
        set_config(16'hFFFF, 16'hFFFF);
        send_message(16'hFFFF, 120, 0, 0);     // left unfinished
        send_message(16'd5, 5, 0, 0);          // sequence 0 mid-message: error
        send_message(16'd5, 5, 0, 0);

        // Random part, up to the byte budget: phases of a few messages each
        // under fresh settings; mostly well-formed messages with random
        // content, some noise, stray frames, broken and unfinished messages.
        msgs_left = 0;
        while (bytes_sent < TOTAL_BYTES) begin
            if (msgs_left == 0) begin
                settle();
                case ($urandom_range(0, 4))
                    0:       len = 16'h0000;
                    1:       len = 16'hFFFF;
                    default: len = 16'($urandom_range(0, 65535));
                endcase
                pick = $urandom_range(0, 99);
                set_config(len, (pick < 10) ? 16'h0000 :
                                (pick < 25) ? 16'hFFFF :
                                (pick < 60) ? 16'($urandom_range(1, 300)) :
                                              16'($urandom_range(100, 2000)));
                msgs_left = $urandom_range(4, 10);
            end
            lim  = (cur_max < 150) ? int'(cur_max) : 150;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_noise();
            end else if (pick < 9) begin
                send_frame(cur_channel, HID_TAG, 16'($urandom_range(1, 65535)),
                           1'b0, 16'd0, 1'b0);
            end else if (pick < 16 || lim == 0) begin
                send_message(16'd0, 0, 4, 3);
            end else if (pick < 22) begin
                if (cur_max != 16'hFFFF) begin
                    len = 16'(cur_max + $urandom_range(1, 65535 - int'(cur_max)));
                    send_message(len, 0, 4, 3);
                end else begin
                    len = 16'($urandom_range(200, 65535));
                    send_message(len, $urandom_range(1, 120), 4, 3);
                end
            end else if (pick < 26 && lim >= 2) begin
                len = 16'($urandom_range(2, lim));
                send_message(len, $urandom_range(0, int'(len) - 1), 4, 3);
            end else begin
                if ($urandom_range(0, 9) < 7)
                    len = 16'($urandom_range(1, (lim < 40) ? lim : 40));
                else
                    len = 16'($urandom_range(1, lim));
                send_message(len, int'(len), 4, 3);
            end
            msgs_left--;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/ahr_pkg.sv
hw/rtl/ahr_parser.sv
hw/rtl/ahr_queue.sv
hw/rtl/ahr_out.sv
hw/rtl/apdu_hid_frame_reassembler.sv
sim/ahr_result_checker.sv
sim/tb.sv
